### rtl/semaphore_gated_flip_queue_assert.svh
`ifndef SEMAPHORE_GATED_FLIP_QUEUE_ASSERT_SVH
`define SEMAPHORE_GATED_FLIP_QUEUE_ASSERT_SVH

// same-cycle implication, ignored while reset is asserted
`define SGFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgfq check failed");

// next-cycle implication, ignored while reset is asserted
`define SGFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgfq check failed");

`endif

### rtl/sgfq_pkg.sv
`default_nettype none

package sgfq_pkg;

  localparam int DEF_HEADS       = 4;
  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_SEMA_SLOTS  = 256;

  localparam logic [2:0] HEADS_RESET = 3'd4;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_POLL    = 2'd1;
  localparam logic [1:0] ACT_DRAIN   = 2'd2;
  localparam logic [1:0] ACT_SLOT_WR = 2'd3;

  localparam logic [1:0] EV_FLIP_DONE = 2'd0;
  localparam logic [1:0] EV_RELEASED  = 2'd1;
  localparam logic [1:0] EV_DROPPED   = 2'd2;
  localparam logic [1:0] EV_PASS_END  = 2'd3;

  typedef struct packed {
    logic        uses;
    logic [7:0]  slot;
    logic [31:0] acq_value;
    logic [31:0] rel_value;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [1:0]  head;
    logic [7:0]  slot;
    logic [31:0] value;
    logic        pend;
    logic        last;
  } event_t;

endpackage

`default_nettype wire

### rtl/sgfq_ram.sv
`default_nettype none

module sgfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/semaphore_gated_flip_queue.sv
`default_nettype none

// Flip queue with semaphore gating. Drive start with an action while busy is low; the
// request is taken at that edge. Results come one per cycle on out_valid and cannot be
// held off, so the receiver must sample every strobe; out_last_event marks the final
// result of a request. Enqueue and slot write complete at the edge that takes them,
// with busy staying low (a dropped enqueue shows its event the cycle after). A poll
// or drain checks each head in use in turn; a completed flip passes through a queue
// memory read, semaphore memory read, release and done, the middle two only where
// needed; a blocked head is read and checked before the pass moves on. A drain also
// releases each head's last semaphore. Each result shows the cycle after it is formed,
// and the pass-finished event closes the request. After reset the semaphore memory is
// cleared slot by slot with busy high; configuration writes are still taken then.
module semaphore_gated_flip_queue #(
  parameter int HEADS       = sgfq_pkg::DEF_HEADS,
  parameter int QUEUE_DEPTH = sgfq_pkg::DEF_QUEUE_DEPTH,
  parameter int SEMA_SLOTS  = sgfq_pkg::DEF_SEMA_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [1:0]  in_head_index,
  input  wire logic        in_uses_semaphore,
  input  wire logic [7:0]  in_sema_slot,
  input  wire logic [31:0] in_acquire_value,
  input  wire logic [31:0] in_release_value,
  input  wire logic [31:0] in_write_value,
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_write_data,
  output logic             out_valid,
  output logic [1:0]       out_event_kind,
  output logic [1:0]       out_event_head,
  output logic [7:0]       out_released_slot,
  output logic [31:0]      out_released_value,
  output logic             out_any_pending,
  output logic             out_last_event
);

  import sgfq_pkg::*;

  localparam int HW  = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam int EW  = $clog2(HEADS + 1);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int QAW = $clog2(HEADS * QUEUE_DEPTH);
  localparam int SW  = $clog2(SEMA_SLOTS);
  localparam int EBITS = $bits(entry_t);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_ENTRY = 3'd3;
  localparam logic [2:0] ST_SEMA  = 3'd4;
  localparam logic [2:0] ST_REL   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  function automatic logic [SW-1:0] slot_mod(input logic [7:0] s);
    logic [20:0] v;
    v = {13'b0, s};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (21'(SEMA_SLOTS) << k)) begin
        v = v - (21'(SEMA_SLOTS) << k);
      end
    end
    return v[SW-1:0];
  endfunction

  function automatic logic [QAW-1:0] qaddr(input logic [HW-1:0] h, input logic [QW-1:0] p);
    return QAW'(h) * QAW'(QUEUE_DEPTH) + QAW'(p);
  endfunction

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    heads_r;
  logic [EW-1:0] eff_heads;
  logic [EW-1:0] cur_head_r, cur_head_nxt;
  logic          force_r, force_nxt;
  logic          pending_r, pending_nxt;
  logic [SW-1:0] clr_cnt_r;

  logic [QW-1:0] wptr_r [HEADS];
  logic [QW-1:0] rptr_r [HEADS];
  logic          prior_valid_r [HEADS];
  logic [7:0]    prior_slot_r [HEADS];
  logic [31:0]   prior_rel_r [HEADS];

  event_t        ev_nxt, ev_r;

  logic [HW-1:0] ch;
  logic [HW-1:0] enq_head;
  logic          accept;
  logic          enq_in_range, enq_full, enq_ok;

  logic             q_we, q_re;
  logic [QAW-1:0]   q_waddr, q_raddr;
  entry_t           q_wdata;
  logic [EBITS-1:0] q_rbits;
  entry_t           q_rd;

  logic          s_we, s_re;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [31:0]   s_wdata, s_rdata;

  // per-head updates requested by the sequencer
  logic          adv_rptr, rec_prior, drop_prior, clear_all;

  assign eff_heads = (heads_r == 3'd0) ? EW'(1) :
                     ({1'b0, heads_r} > 4'(HEADS)) ? EW'(HEADS) : EW'(heads_r);
  assign ch       = cur_head_r[HW-1:0];
  assign enq_head = HW'(in_head_index);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;

  assign enq_in_range = ({2'b0, in_head_index} < 4'(eff_heads));
  assign enq_full     = (ptr_inc(wptr_r[enq_head]) == rptr_r[enq_head]);
  assign enq_ok       = enq_in_range && !enq_full;
  assign q_rd         = entry_t'(q_rbits);

  sgfq_ram #(.WIDTH(EBITS), .DEPTH(HEADS * QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rbits)
  );

  sgfq_ram #(.WIDTH(32), .DEPTH(SEMA_SLOTS)) u_sema_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    cur_head_nxt = cur_head_r;
    force_nxt    = force_r;
    pending_nxt  = pending_r;
    ev_nxt       = '0;
    q_we         = 1'b0;
    q_waddr      = qaddr(enq_head, wptr_r[enq_head]);
    q_wdata.uses      = in_uses_semaphore;
    q_wdata.slot      = in_uses_semaphore ? in_sema_slot : 8'd0;
    q_wdata.acq_value = in_uses_semaphore ? in_acquire_value : 32'd0;
    q_wdata.rel_value = in_uses_semaphore ? in_release_value : 32'd0;
    q_re         = 1'b0;
    q_raddr      = qaddr(ch, rptr_r[ch]);
    s_we         = 1'b0;
    s_waddr      = slot_mod(prior_slot_r[ch]);
    s_wdata      = prior_rel_r[ch];
    s_re         = 1'b0;
    s_raddr      = slot_mod(q_rd.slot);
    adv_rptr     = 1'b0;
    rec_prior    = 1'b0;
    drop_prior   = 1'b0;
    clear_all    = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_cnt_r;
        s_wdata = 32'd0;
        if (clr_cnt_r == SW'(SEMA_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (in_action)
            ACT_ENQUEUE: begin
              if (enq_ok) begin
                q_we = 1'b1;
              end else begin
                ev_nxt.valid = 1'b1;
                ev_nxt.kind  = EV_DROPPED;
                ev_nxt.head  = in_head_index;
                ev_nxt.last  = 1'b1;
              end
            end
            ACT_SLOT_WR: begin
              s_we    = 1'b1;
              s_waddr = slot_mod(in_sema_slot);
              s_wdata = in_write_value;
            end
            default: begin
              state_nxt    = ST_HEAD;
              cur_head_nxt = '0;
              pending_nxt  = 1'b0;
              force_nxt    = (in_action == ACT_DRAIN);
            end
          endcase
        end
      end
      ST_HEAD: begin
        if (cur_head_r >= eff_heads) begin
          ev_nxt.valid = 1'b1;
          ev_nxt.kind  = EV_PASS_END;
          ev_nxt.pend  = pending_r;
          ev_nxt.last  = 1'b1;
          clear_all    = force_r;
          state_nxt    = ST_IDLE;
        end else if (rptr_r[ch] == wptr_r[ch]) begin
          // drain releases the head's last semaphore once its queue is empty
          if (force_r && prior_valid_r[ch]) begin
            s_we         = 1'b1;
            ev_nxt.valid = 1'b1;
            ev_nxt.kind  = EV_RELEASED;
            ev_nxt.head  = 2'(cur_head_r);
            ev_nxt.slot  = prior_slot_r[ch];
            ev_nxt.value = prior_rel_r[ch];
            drop_prior   = 1'b1;
          end else begin
            cur_head_nxt = cur_head_r + 1'b1;
          end
        end else begin
          q_re      = 1'b1;
          state_nxt = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        if (!q_rd.uses) begin
          state_nxt = ST_DONE;
        end else if (force_r) begin
          state_nxt = prior_valid_r[ch] ? ST_REL : ST_DONE;
        end else begin
          s_re      = 1'b1;
          state_nxt = ST_SEMA;
        end
      end
      ST_SEMA: begin
        if (s_rdata == q_rd.acq_value) begin
          state_nxt = prior_valid_r[ch] ? ST_REL : ST_DONE;
        end else begin
          pending_nxt  = 1'b1;
          cur_head_nxt = cur_head_r + 1'b1;
          state_nxt    = ST_HEAD;
        end
      end
      ST_REL: begin
        s_we         = 1'b1;
        ev_nxt.valid = 1'b1;
        ev_nxt.kind  = EV_RELEASED;
        ev_nxt.head  = 2'(cur_head_r);
        ev_nxt.slot  = prior_slot_r[ch];
        ev_nxt.value = prior_rel_r[ch];
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        ev_nxt.valid = 1'b1;
        ev_nxt.kind  = EV_FLIP_DONE;
        ev_nxt.head  = 2'(cur_head_r);
        adv_rptr     = 1'b1;
        rec_prior    = q_rd.uses;
        state_nxt    = ST_HEAD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      heads_r    <= HEADS_RESET;
      cur_head_r <= '0;
      force_r    <= 1'b0;
      pending_r  <= 1'b0;
      clr_cnt_r  <= '0;
      ev_r       <= '0;
      for (int h = 0; h < HEADS; h++) begin
        wptr_r[h]        <= '0;
        rptr_r[h]        <= '0;
        prior_valid_r[h] <= 1'b0;
      end
    end else begin
      state_r    <= state_nxt;
      cur_head_r <= cur_head_nxt;
      force_r    <= force_nxt;
      pending_r  <= pending_nxt;
      ev_r       <= ev_nxt;
      if (cfg_write_en) begin
        heads_r <= cfg_write_data;
      end
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (accept && (in_action == ACT_ENQUEUE) && enq_ok) begin
        wptr_r[enq_head] <= ptr_inc(wptr_r[enq_head]);
      end
      if (adv_rptr) begin
        rptr_r[ch] <= ptr_inc(rptr_r[ch]);
      end
      if (rec_prior) begin
        prior_valid_r[ch] <= 1'b1;
      end
      if (drop_prior) begin
        prior_valid_r[ch] <= 1'b0;
      end
      if (clear_all) begin
        for (int h = 0; h < HEADS; h++) begin
          wptr_r[h]        <= '0;
          rptr_r[h]        <= '0;
          prior_valid_r[h] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_prior) begin
      prior_slot_r[ch] <= q_rd.slot;
      prior_rel_r[ch]  <= q_rd.rel_value;
    end
  end

  assign out_valid          = ev_r.valid;
  assign out_event_kind     = ev_r.kind;
  assign out_event_head     = ev_r.head;
  assign out_released_slot  = ev_r.slot;
  assign out_released_value = ev_r.value;
  assign out_any_pending    = ev_r.pend;
  assign out_last_event     = ev_r.last;

endmodule

`default_nettype wire

### rtl/sgfq_checker.sv
`default_nettype none

`include "semaphore_gated_flip_queue_assert.svh"

module sgfq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_action,
  input wire logic        out_valid,
  input wire logic [1:0]  out_event_kind,
  input wire logic [7:0]  out_released_slot,
  input wire logic [31:0] out_released_value,
  input wire logic        out_last_event
);

  import sgfq_pkg::*;

  // a pass always runs on after the request is taken
  `SGFQ_ASSERT_NEXT(a_pass_busy, start && !busy && (in_action == ACT_POLL || in_action == ACT_DRAIN), busy)

  // a result that is not the last of its request only shows mid-pass
  `SGFQ_ASSERT_NOW(a_mid_busy, out_valid && !out_last_event, busy)

  `SGFQ_ASSERT_NOW(a_pass_last, out_valid && out_event_kind == EV_PASS_END, out_last_event)

  `SGFQ_ASSERT_NOW(a_last_kind, out_valid && out_last_event, out_event_kind == EV_PASS_END || out_event_kind == EV_DROPPED)

  // only release events carry a slot and payload
  `SGFQ_ASSERT_NOW(a_rel_fields, out_valid && out_event_kind != EV_RELEASED, out_released_slot == 8'd0 && out_released_value == 32'd0)

endmodule

bind semaphore_gated_flip_queue sgfq_checker u_sgfq_checker (.*);

`default_nettype wire
